// File: rtl/wsu_pkg.sv
package wsu_pkg;

	// One received frame byte and its start-of-frame flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] payload_byte;
		logic       last;
		logic       binary;
	} out_item_t;

	// Work handed from the header parser to the output side. One input item
	// can yield a truncation notice for the cut frame and one result of its own.
	typedef struct packed {
		logic      trunc;
		logic      trunc_binary;
		logic      main_valid;
		out_item_t main;
	} q_entry_t;

	// Result kinds.
	localparam logic [2:0] KIND_DATA  = 3'd0;
	localparam logic [2:0] KIND_EMPTY = 3'd1;
	localparam logic [2:0] KIND_BAD   = 3'd2;
	localparam logic [2:0] KIND_LONG  = 3'd3;
	localparam logic [2:0] KIND_TRUNC = 3'd4;

	// Frame header constants.
	localparam logic [7:0] OPCODE_TEXT   = 8'h81;
	localparam logic [7:0] OPCODE_BINARY = 8'h82;
	localparam logic [6:0] LEN_CODE_MAX  = 7'd125;
	localparam logic [6:0] LEN_CODE_16   = 7'd126;

	// Configuration register map.
	localparam logic [2:0]  ADDR_MAX_LENGTH  = 3'd0;
	localparam logic [31:0] MAX_LENGTH_RESET = 32'd8095;

endpackage

// File: rtl/wsu_front.sv
module wsu_front
	import wsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_fire,
	input  in_item_t    item,
	input  logic [31:0] max_length,
	output logic        push,
	output q_entry_t    push_entry
);

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_LEN     = 7'b0000010,
		PH_EXT16   = 7'b0000100,
		PH_EXT64   = 7'b0001000,
		PH_MASK    = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_DISCARD = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] len_q, len_d;
	logic        upper_q, upper_d;
	logic [31:0] key_q, key_d;
	logic [31:0] pay_cnt_q, pay_cnt_d;
	logic        bin_q, bin_d;

	logic        len_check;
	logic [31:0] pay_inc;
	logic [7:0]  key_byte;
	logic [6:0]  len_code;
	logic [7:0]  b;
	q_entry_t    entry;

	assign b        = item.data_byte;
	assign len_code = b[6:0];
	assign pay_inc  = pay_cnt_q + 32'd1;

	// Mask key byte for this payload position, first key byte first.
	always_comb begin
		case (pay_cnt_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Header parser: works out the next state and the results of each item.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		upper_d   = upper_q;
		key_d     = key_q;
		pay_cnt_d = pay_cnt_q;
		bin_d     = bin_q;
		len_check = 1'b0;
		entry     = '0;

		if (item_fire) begin
			if (item.frame_start) begin
				// A new start cuts short any frame still in its header or payload.
				if (phase_q != PH_IDLE && phase_q != PH_DISCARD) begin
					entry.trunc        = 1'b1;
					entry.trunc_binary = bin_q;
				end
				hdr_cnt_d = '0;
				len_d     = '0;
				upper_d   = 1'b0;
				key_d     = '0;
				pay_cnt_d = '0;
				if (b == OPCODE_TEXT || b == OPCODE_BINARY) begin
					bin_d   = (b == OPCODE_BINARY);
					phase_d = PH_LEN;
				end else begin
					bin_d                   = 1'b0;
					entry.main_valid        = 1'b1;
					entry.main.kind         = KIND_BAD;
					entry.main.last         = 1'b1;
					phase_d                 = PH_DISCARD;
				end
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						hdr_cnt_d = '0;
						len_d     = '0;
						upper_d   = 1'b0;
						if (len_code <= LEN_CODE_MAX) begin
							len_d     = {25'd0, len_code};
							len_check = 1'b1;
						end else if (len_code == LEN_CODE_16) begin
							phase_d = PH_EXT16;
						end else begin
							phase_d = PH_EXT64;
						end
					end
					PH_EXT16: begin
						len_d     = {16'd0, len_q[7:0], b};
						hdr_cnt_d = hdr_cnt_q + 3'd1;
						len_check = (hdr_cnt_q == 3'd1);
					end
					PH_EXT64: begin
						// The upper word only has to be zero; the lower word is the length.
						if (!hdr_cnt_q[2]) begin
							upper_d = upper_q | (b != 8'd0);
						end else begin
							len_d = {len_q[23:0], b};
						end
						hdr_cnt_d = hdr_cnt_q + 3'd1;
						len_check = (hdr_cnt_q == 3'd7);
					end
					PH_MASK: begin
						key_d     = {key_q[23:0], b};
						hdr_cnt_d = hdr_cnt_q + 3'd1;
						if (hdr_cnt_q == 3'd3) begin
							hdr_cnt_d = '0;
							pay_cnt_d = '0;
							if (len_q == 32'd0) begin
								entry.main_valid  = 1'b1;
								entry.main.kind   = KIND_EMPTY;
								entry.main.last   = 1'b1;
								entry.main.binary = bin_q;
								phase_d           = PH_IDLE;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						entry.main_valid        = 1'b1;
						entry.main.kind         = KIND_DATA;
						entry.main.payload_byte = b ^ key_byte;
						entry.main.last         = (pay_inc == len_q);
						entry.main.binary       = bin_q;
						pay_cnt_d               = pay_inc;
						if (pay_inc == len_q) begin
							phase_d = PH_IDLE;
						end
					end
					PH_IDLE, PH_DISCARD: begin
						// Stray bytes outside a frame are dropped.
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase

				// Length fully known: reject it or move on to the mask key.
				if (len_check) begin
					if (upper_d || len_d > max_length) begin
						entry.main_valid  = 1'b1;
						entry.main.kind   = KIND_LONG;
						entry.main.last   = 1'b1;
						entry.main.binary = bin_q;
						phase_d           = PH_DISCARD;
					end else begin
						phase_d   = PH_MASK;
						hdr_cnt_d = '0;
						key_d     = '0;
					end
				end
			end
		end
	end

	assign push       = entry.trunc | entry.main_valid;
	assign push_entry = entry;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			upper_q   <= 1'b0;
			key_q     <= '0;
			pay_cnt_q <= '0;
			bin_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			upper_q   <= upper_d;
			key_q     <= key_d;
			pay_cnt_q <= pay_cnt_d;
			bin_q     <= bin_d;
		end
	end

endmodule

// File: rtl/wsu_queue.sv
module wsu_queue
	import wsu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output q_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/wsu_back.sv
module wsu_back
	import wsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  q_entry_t  q_head,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      res_valid_q;
	out_item_t res_q;
	logic      hold_valid_q;
	out_item_t hold_q;
	logic      load;
	out_item_t trunc_item;

	// The notice for a cut frame.
	always_comb begin
		trunc_item        = '0;
		trunc_item.kind   = KIND_TRUNC;
		trunc_item.last   = 1'b1;
		trunc_item.binary = q_head.trunc_binary;
	end

	// The output register is free when empty or being taken this cycle.
	assign load  = !res_valid_q || result_ready;
	assign q_pop = load && !hold_valid_q && !q_empty;

	// Output and second-result valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (load) begin
			if (hold_valid_q) begin
				res_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (!q_empty) begin
				res_valid_q  <= 1'b1;
				hold_valid_q <= q_head.trunc && q_head.main_valid;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output and second-result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (hold_valid_q) begin
				res_q <= hold_q;
			end else if (!q_empty) begin
				if (q_head.trunc) begin
					res_q  <= trunc_item;
					hold_q <= q_head.main;
				end else begin
					res_q <= q_head.main;
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: rtl/websocket_frame_unmasker.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    in_item_t  (data_byte, frame_start)
// result    out        result_valid / result_ready out_item_t (kind, payload_byte, last,
//                                                  binary)
// apb       in         psel, penable, pwrite      max_length at byte address 0
//
// One item is taken per cycle while the queue has room. Each item is parsed in the
// cycle it is taken; its results pass through the queue to the output register.
// An item that cuts a frame short and opens a new one with a bad first byte gives
// two results, sent one after the other; the queue absorbs this.
// item_ready is low only while the queue of QUEUE_DEPTH entries is full.
// Reset is asynchronous and puts the parser idle and max_length at 8095.
module websocket_frame_unmasker
	import wsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] max_length_q;
	logic        item_fire;
	logic        push;
	q_entry_t    push_entry;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	q_entry_t    q_head;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_LENGTH) ? max_length_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_MAX_LENGTH) begin
			max_length_q <= pwdata;
		end
	end

	// Input handshake.
	assign item_ready = !q_full;
	assign item_fire  = item_valid && item_ready;

	wsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_fire  (item_fire),
		.item       (item),
		.max_length (max_length_q),
		.push       (push),
		.push_entry (push_entry)
	);

	wsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	wsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/wsu_checker.sv
module wsu_checker
	import wsu_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	// Every result other than a payload byte closes its frame.
	a_nondata_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_DATA |-> result.last)
		else $error("non-data result without last");

	// Only payload bytes carry data.
	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_DATA |-> result.payload_byte == 8'd0)
		else $error("non-data result with nonzero byte");

	// A bad header has no known frame type.
	a_bad_text: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_BAD |-> !result.binary)
		else $error("bad header result marked binary");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

endmodule

bind websocket_frame_unmasker wsu_checker u_wsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
